// ===== hw/rtl/wavp_pkg.sv =====
// shared types and constants for the pcm16 mono wav stream parser
// no dependencies; used by the top level and its checker
package wavp_pkg;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [31:0] DefaultRateReset = 32'd16000;
  localparam logic [15:0] NeededBits       = 16'd16;
  localparam logic [15:0] FormatPcm        = 16'd1;
  localparam logic [15:0] MonoChannels     = 16'd1;
  localparam logic [3:0]  FmtHeadLast      = 4'd15;

  localparam int unsigned AddrWidth = 3;
  localparam logic        RegDefaultRate = 1'b0;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_CHDR = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_IDLE = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR_OK     = 2'd0,
    KIND_SAMPLE     = 2'd1,
    KIND_HDR_REJECT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NOT_RIFF    = 2'd1,
    ERR_MISSING     = 2'd2,
    ERR_UNSUPPORTED = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         error_code;
    logic [31:0]        sample_rate;
    logic signed [15:0] sample;
    logic               last_sample;
  } out_item_t;

endpackage

// ===== hw/rtl/wav_pcm16_mono_stream_parser_top.sv =====
// top level of the pcm16 mono wav stream parser: byte-wide header walker and sample packer
// depends on wavp_pkg
//
// usage: the in channel carries one file byte per transfer plus an end_of_file flag on
// the final byte. the out channel carries at most one result per byte: header accepted
// (with the sample rate, default_rate when the header gives 0), header rejected (with an
// error code) or one 16-bit sample with a last flag. the apb port holds default_rate at
// address 0; the user must write it only while the stream is idle, as the block does not
// enforce this. the result of a transferred byte goes into the output register and is
// presented on the out channel from there. throughput: one byte per cycle; all per-byte
// work sits between the parser state and the output register, so the output register
// handshake alone sets the rate.
// stalls: a byte is taken whenever the output register is empty or is being drained in
// the same cycle, so a stalled receiver holds back the byte stream one result deep.
// reset: the parser waits for a riff preamble, the output register is empty and
// default_rate returns to 16000. no clearing pass is needed. after the end_of_file byte
// the parser rearms by itself.
module wav_pcm16_mono_stream_parser_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wavp_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wavp_pkg::out_item_t                out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wavp_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  wavp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] fmt_code_q, fmt_code_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] hdr_rate_q, hdr_rate_d;
  logic [15:0] depth_q, depth_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  low_q, low_d;
  logic        half_q, half_d;
  logic [31:0] default_rate_q;

  logic                out_valid_q;
  wavp_pkg::out_item_t out_q, res;
  logic                res_valid;
  logic                in_fire;
  logic [7:0]          b;
  logic                eof;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[wavp_pkg::AddrWidth-1] == wavp_pkg::RegDefaultRate) ?
                  default_rate_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_rate_q <= wavp_pkg::DefaultRateReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[wavp_pkg::AddrWidth-1] == wavp_pkg::RegDefaultRate) begin
      default_rate_q <= pwdata;
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = in_data_i.file_byte;
  assign eof        = in_data_i.end_of_file;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    len_d      = len_q;
    skip_d     = skip_q;
    fmt_code_d = fmt_code_q;
    chans_d    = chans_q;
    hdr_rate_d = hdr_rate_q;
    depth_d    = depth_q;
    fmt_seen_d = fmt_seen_q;
    remain_d   = remain_q;
    low_d      = low_q;
    half_d     = half_q;
    res_valid  = 1'b0;
    res        = '0;

    case (phase_q)
      wavp_pkg::PH_RIFF: begin
        if (pos_q < 4'd4 || pos_q >= 4'd8) begin
          tag_d = {tag_q[23:0], b};
        end
        if ((pos_q == 4'd3 && tag_d != wavp_pkg::TagRiff) ||
            (pos_q == 4'd11 && tag_d != wavp_pkg::TagWave)) begin
          phase_d        = wavp_pkg::PH_IDLE;
          res_valid      = 1'b1;
          res.kind       = wavp_pkg::KIND_HDR_REJECT;
          res.error_code = wavp_pkg::ERR_NOT_RIFF;
        end else if (pos_q == 4'd11) begin
          phase_d = wavp_pkg::PH_CHDR;
          pos_d   = 4'd0;
          tag_d   = 32'd0;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      wavp_pkg::PH_CHDR: begin
        if (pos_q < 4'd4) begin
          tag_d = {tag_q[23:0], b};
        end else begin
          len_d = {b, len_q[31:8]};
        end
        if (pos_q >= 4'd7) begin
          if (tag_d == wavp_pkg::TagFmt) begin
            fmt_code_d = 16'd0;
            chans_d    = 16'd0;
            hdr_rate_d = 32'd0;
            depth_d    = 16'd0;
            fmt_seen_d = 1'b1;
            skip_d     = len_d;
            pos_d      = 4'd0;
            phase_d    = (len_d == 32'd0) ? wavp_pkg::PH_CHDR : wavp_pkg::PH_FMT;
          end else if (tag_d == wavp_pkg::TagData) begin
            remain_d  = len_d;
            half_d    = 1'b0;
            res_valid = 1'b1;
            if (!fmt_seen_q) begin
              phase_d        = wavp_pkg::PH_IDLE;
              res.kind       = wavp_pkg::KIND_HDR_REJECT;
              res.error_code = wavp_pkg::ERR_MISSING;
            end else if (fmt_code_q != wavp_pkg::FormatPcm ||
                         depth_q != wavp_pkg::NeededBits ||
                         chans_q != wavp_pkg::MonoChannels) begin
              phase_d        = wavp_pkg::PH_IDLE;
              res.kind       = wavp_pkg::KIND_HDR_REJECT;
              res.error_code = wavp_pkg::ERR_UNSUPPORTED;
            end else begin
              phase_d         = wavp_pkg::PH_DATA;
              res.kind        = wavp_pkg::KIND_HDR_OK;
              res.sample_rate = (hdr_rate_q != 32'd0) ? hdr_rate_q : default_rate_q;
            end
          end else begin
            skip_d  = len_d;
            pos_d   = 4'd0;
            phase_d = (len_d == 32'd0) ? wavp_pkg::PH_CHDR : wavp_pkg::PH_SKIP;
          end
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      wavp_pkg::PH_FMT: begin
        case (pos_q)
          4'd0:    fmt_code_d[7:0]  = b;
          4'd1:    fmt_code_d[15:8] = b;
          4'd2:    chans_d[7:0]     = b;
          4'd3:    chans_d[15:8]    = b;
          4'd4:    hdr_rate_d[7:0]   = b;
          4'd5:    hdr_rate_d[15:8]  = b;
          4'd6:    hdr_rate_d[23:16] = b;
          4'd7:    hdr_rate_d[31:24] = b;
          4'd14:   depth_d[7:0]     = b;
          4'd15:   depth_d[15:8]    = b;
          default: ;
        endcase
        skip_d = skip_q - 32'd1;
        if (skip_d == 32'd0) begin
          phase_d = wavp_pkg::PH_CHDR;
          pos_d   = 4'd0;
        end else if (pos_q >= wavp_pkg::FmtHeadLast) begin
          // rest of a long fmt chunk is skipped
          phase_d = wavp_pkg::PH_SKIP;
          pos_d   = 4'd0;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
      wavp_pkg::PH_SKIP: begin
        if (skip_q != 32'd0) begin
          skip_d = skip_q - 32'd1;
        end
        if (skip_d == 32'd0) begin
          phase_d = wavp_pkg::PH_CHDR;
          pos_d   = 4'd0;
        end
      end
      wavp_pkg::PH_DATA: begin
        if (remain_q != 32'd0) begin
          remain_d = remain_q - 32'd1;
          if (!half_q) begin
            low_d  = b;
            half_d = 1'b1;
          end else begin
            half_d          = 1'b0;
            res_valid       = 1'b1;
            res.kind        = wavp_pkg::KIND_SAMPLE;
            res.sample      = {b, low_q};
            res.last_sample = (remain_d < 32'd2) || eof;
          end
        end
      end
      default: ;
    endcase

    // end of file: report a truncated header unless this byte already produced a result
    if (eof && !res_valid) begin
      if (phase_d == wavp_pkg::PH_RIFF) begin
        res_valid      = 1'b1;
        res.kind       = wavp_pkg::KIND_HDR_REJECT;
        res.error_code = wavp_pkg::ERR_NOT_RIFF;
      end else if (phase_d == wavp_pkg::PH_CHDR || phase_d == wavp_pkg::PH_FMT ||
                   phase_d == wavp_pkg::PH_SKIP) begin
        res_valid      = 1'b1;
        res.kind       = wavp_pkg::KIND_HDR_REJECT;
        res.error_code = wavp_pkg::ERR_MISSING;
      end
    end
    if (eof) begin
      phase_d    = wavp_pkg::PH_RIFF;
      pos_d      = 4'd0;
      tag_d      = 32'd0;
      len_d      = 32'd0;
      skip_d     = 32'd0;
      fmt_code_d = 16'd0;
      chans_d    = 16'd0;
      hdr_rate_d = 32'd0;
      depth_d    = 16'd0;
      fmt_seen_d = 1'b0;
      remain_d   = 32'd0;
      low_d      = 8'd0;
      half_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wavp_pkg::PH_RIFF;
      pos_q      <= 4'd0;
      tag_q      <= 32'd0;
      len_q      <= 32'd0;
      skip_q     <= 32'd0;
      fmt_code_q <= 16'd0;
      chans_q    <= 16'd0;
      hdr_rate_q <= 32'd0;
      depth_q    <= 16'd0;
      fmt_seen_q <= 1'b0;
      remain_q   <= 32'd0;
      low_q      <= 8'd0;
      half_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      skip_q     <= skip_d;
      fmt_code_q <= fmt_code_d;
      chans_q    <= chans_d;
      hdr_rate_q <= hdr_rate_d;
      depth_q    <= depth_d;
      fmt_seen_q <= fmt_seen_d;
      remain_q   <= remain_d;
      low_q      <= low_d;
      half_q     <= half_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/wavp_checker.sv =====
// port-level checker for the wav stream parser, bound to the top level
// depends on wavp_pkg and wav_pcm16_mono_stream_parser_top
module wavp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input wavp_pkg::out_item_t out_data_o
);

  // a stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input side never blocks while the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // samples carry no error and no rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == wavp_pkg::KIND_SAMPLE |->
      out_data_o.error_code == wavp_pkg::ERR_NONE && out_data_o.sample_rate == 32'd0)
    else $error("sample result with error or rate");

  // rejections always carry a cause, no sample fields and no rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == wavp_pkg::KIND_HDR_REJECT |->
      out_data_o.error_code != wavp_pkg::ERR_NONE && out_data_o.sample == 16'sd0 &&
      !out_data_o.last_sample && out_data_o.sample_rate == 32'd0)
    else $error("malformed rejection");

  // accepted header has no error and no last-sample flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == wavp_pkg::KIND_HDR_OK |->
      out_data_o.error_code == wavp_pkg::ERR_NONE && !out_data_o.last_sample)
    else $error("malformed header acceptance");

endmodule

bind wav_pcm16_mono_stream_parser_top wavp_checker u_wavp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== dv/tb_wav_pcm16_mono_stream_parser_top.sv =====
// testbench for the pcm16 mono wav stream parser: streams wav files byte by byte,
// predicts every header verdict and sample in step with the input, and checks the output
// depends on wavp_pkg and wav_pcm16_mono_stream_parser_top
module tb_wav_pcm16_mono_stream_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [wavp_pkg::AddrWidth-1:0] addr_t;

  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned RandomBytes = 1700;
  localparam logic [31:0] TagList     = 32'h4C49_5354;
  localparam logic [15:0] FormatFloat = 16'd3;
  localparam addr_t       RateAddr    = addr_t'(4 * wavp_pkg::RegDefaultRate);

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  wavp_pkg::in_item_t   in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  wavp_pkg::out_item_t  out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  addr_t                paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  wav_pcm16_mono_stream_parser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // parser state as the testbench sees it
  logic [31:0]      rate_setting;
  wavp_pkg::phase_e ph;
  logic [3:0]       hdr_pos;
  logic [31:0]      tag_acc;
  logic [31:0]      len_acc;
  logic [31:0]      skip_left;
  logic [31:0]      rate_field;
  logic [31:0]      data_left;
  logic [15:0]      fmt_code;
  logic [15:0]      chan_count;
  logic [15:0]      bit_depth;
  logic             fmt_seen;
  logic             odd_byte;
  logic [7:0]       low_byte;

  wavp_pkg::out_item_t wav_results_q[$];
  logic [7:0]   wav_bytes[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  logic         full_rate = 1'b0;

  function automatic void rearm_parser();
    ph = wavp_pkg::PH_RIFF;
    hdr_pos = '0;
    tag_acc = '0;
    len_acc = '0;
    skip_left = '0;
    rate_field = '0;
    data_left = '0;
    fmt_code = '0;
    chan_count = '0;
    bit_depth = '0;
    fmt_seen = 1'b0;
    odd_byte = 1'b0;
    low_byte = '0;
  endfunction

  function automatic wavp_pkg::out_item_t header_result(wavp_pkg::kind_e k, wavp_pkg::err_e e,
                                                        logic [31:0] rate);
    wavp_pkg::out_item_t r;
    r = '0;
    r.kind = k;
    r.error_code = e;
    r.sample_rate = rate;
    return r;
  endfunction

  // advance the parser state by one byte and queue the result it causes, if any
  function automatic void parse_byte(wavp_pkg::in_item_t it);
    wavp_pkg::out_item_t res;
    logic       got;
    logic [7:0] b;
    res = '0;
    got = 1'b0;
    b = it.file_byte;
    case (ph)
      wavp_pkg::PH_RIFF: begin
        if (hdr_pos < 4 || hdr_pos >= 8) tag_acc = {tag_acc[23:0], b};
        if ((hdr_pos == 4'd3 && tag_acc != wavp_pkg::TagRiff) ||
            (hdr_pos == 4'd11 && tag_acc != wavp_pkg::TagWave)) begin
          ph = wavp_pkg::PH_IDLE;
          res = header_result(wavp_pkg::KIND_HDR_REJECT, wavp_pkg::ERR_NOT_RIFF, '0);
          got = 1'b1;
        end else if (hdr_pos == 4'd11) begin
          ph = wavp_pkg::PH_CHDR;
          hdr_pos = '0;
          tag_acc = '0;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      wavp_pkg::PH_CHDR: begin
        if (hdr_pos < 4) tag_acc = {tag_acc[23:0], b};
        else len_acc = {b, len_acc[31:8]};
        if (hdr_pos >= 4'd7) begin
          if (tag_acc == wavp_pkg::TagFmt) begin
            fmt_code = '0;
            chan_count = '0;
            rate_field = '0;
            bit_depth = '0;
            fmt_seen = 1'b1;
            skip_left = len_acc;
            hdr_pos = '0;
            if (len_acc == '0) ph = wavp_pkg::PH_CHDR;
            else ph = wavp_pkg::PH_FMT;
          end else if (tag_acc == wavp_pkg::TagData) begin
            data_left = len_acc;
            odd_byte = 1'b0;
            got = 1'b1;
            if (!fmt_seen) begin
              ph = wavp_pkg::PH_IDLE;
              res = header_result(wavp_pkg::KIND_HDR_REJECT, wavp_pkg::ERR_MISSING, '0);
            end else if (fmt_code != wavp_pkg::FormatPcm ||
                         bit_depth != wavp_pkg::NeededBits ||
                         chan_count != wavp_pkg::MonoChannels) begin
              ph = wavp_pkg::PH_IDLE;
              res = header_result(wavp_pkg::KIND_HDR_REJECT, wavp_pkg::ERR_UNSUPPORTED, '0);
            end else begin
              ph = wavp_pkg::PH_DATA;
              res = header_result(wavp_pkg::KIND_HDR_OK, wavp_pkg::ERR_NONE,
                                  (rate_field != '0) ? rate_field : rate_setting);
            end
          end else begin
            skip_left = len_acc;
            hdr_pos = '0;
            if (len_acc == '0) ph = wavp_pkg::PH_CHDR;
            else ph = wavp_pkg::PH_SKIP;
          end
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      wavp_pkg::PH_FMT: begin
        case (hdr_pos)
          4'd0: fmt_code[7:0] = b;
          4'd1: fmt_code[15:8] = b;
          4'd2: chan_count[7:0] = b;
          4'd3: chan_count[15:8] = b;
          4'd4, 4'd5, 4'd6, 4'd7: rate_field[8 * (hdr_pos - 4'd4) +: 8] = b;
          4'd14: bit_depth[7:0] = b;
          4'd15: bit_depth[15:8] = b;
          default: ;
        endcase
        skip_left = skip_left - 1;
        if (skip_left == '0) begin
          ph = wavp_pkg::PH_CHDR;
          hdr_pos = '0;
        end else if (hdr_pos >= wavp_pkg::FmtHeadLast) begin
          ph = wavp_pkg::PH_SKIP;
          hdr_pos = '0;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      wavp_pkg::PH_SKIP: begin
        if (skip_left != '0) skip_left = skip_left - 1;
        if (skip_left == '0) begin
          ph = wavp_pkg::PH_CHDR;
          hdr_pos = '0;
        end
      end
      wavp_pkg::PH_DATA: begin
        if (data_left != '0) begin
          data_left = data_left - 1;
          if (!odd_byte) begin
            low_byte = b;
            odd_byte = 1'b1;
          end else begin
            odd_byte = 1'b0;
            res.kind = wavp_pkg::KIND_SAMPLE;
            res.sample = {b, low_byte};
            res.last_sample = (data_left < 2) || it.end_of_file;
            got = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // end of file closes any unfinished header
    if (it.end_of_file && !got) begin
      if (ph == wavp_pkg::PH_RIFF) begin
        res = header_result(wavp_pkg::KIND_HDR_REJECT, wavp_pkg::ERR_NOT_RIFF, '0);
        got = 1'b1;
      end else if (ph == wavp_pkg::PH_CHDR || ph == wavp_pkg::PH_FMT ||
                   ph == wavp_pkg::PH_SKIP) begin
        res = header_result(wavp_pkg::KIND_HDR_REJECT, wavp_pkg::ERR_MISSING, '0);
        got = 1'b1;
      end
    end
    if (it.end_of_file) rearm_parser();
    if (got) wav_results_q.push_back(res);
  endfunction

  function automatic int unsigned stall_cycles();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // receiver side: random stalls unless a full-rate stretch is running
  always @(posedge clk_i) begin : ready_drive
    int unsigned hold;
    hold = stall_left;
    if (hold == 0 && !full_rate && $urandom_range(0, 3) == 0) hold = stall_cycles();
    out_ready_i <= (hold == 0);
    stall_left <= (hold == 0) ? 0 : hold - 1;
  end

  always @(posedge clk_i) begin : result_check
    wavp_pkg::out_item_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (wav_results_q.size() == 0) begin
        $display("%0t: result mismatch, expected none, actual kind %0h err %0h rate %0h",
                 $time, out_data_o.kind, out_data_o.error_code, out_data_o.sample_rate);
        mismatch_count++;
      end else begin
        want = wav_results_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data_o.kind));
        check_field("error_code", 32'(want.error_code), 32'(out_data_o.error_code));
        check_field("sample_rate", want.sample_rate, out_data_o.sample_rate);
        check_field("sample", 32'(want.sample), 32'(out_data_o.sample));
        check_field("last_sample", 32'(want.last_sample), 32'(out_data_o.last_sample));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int unsigned        gap;
    wavp_pkg::in_item_t it;
    gap = (full_rate || $urandom_range(0, 1) == 0) ? 0 : stall_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.file_byte = b;
    it.end_of_file = eof;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    parse_byte(it);
  endtask

  // hold the input until every predicted result has been taken
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (wav_results_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [31:0] v);
    drain(3);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RateAddr;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rate_setting = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("default_rate readback", v, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) wav_bytes.push_back(t[8 * i +: 8]);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_random(int unsigned n);
    repeat (n) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_chunk(logic [31:0] t, logic [31:0] len);
    put_tag(t);
    put_le(len, 4);
  endfunction

  function automatic void put_preamble();
    put_tag(wavp_pkg::TagRiff);
    put_le($urandom, 4);
    put_tag(wavp_pkg::TagWave);
  endfunction

  // fmt chunk of any length: the 16-byte head is cut short or padded with random bytes
  function automatic void put_fmt(logic [31:0] len, logic [15:0] code, logic [15:0] chans,
                                  logic [31:0] rate, logic [15:0] bits);
    logic [127:0] head;
    head = {bits, 16'($urandom), 32'($urandom), rate, chans, code};
    put_chunk(wavp_pkg::TagFmt, len);
    for (int i = 0; i < len; i++) begin
      if (i < 16) wav_bytes.push_back(head[8 * i +: 8]);
      else wav_bytes.push_back(8'($urandom));
    end
  endfunction

  // the last byte of the file carries end_of_file
  task automatic send_file(input int unsigned pause_pct);
    for (int i = 0; i < wav_bytes.size(); i++) begin
      if ($urandom_range(0, 99) < pause_pct) drain(0);
      send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    end
    wav_bytes.delete();
  endtask

  task automatic test_preamble_errors();
    // wrong first tag, rest of the file ignored
    put_tag(32'h5249_4658);
    put_random(5);
    send_file(0);
    // wrong form tag on the twelfth byte
    put_tag(wavp_pkg::TagRiff);
    put_le(36, 4);
    put_tag(32'h5741_5646);
    put_random(2);
    send_file(0);
    // file ends inside the preamble
    put_tag(wavp_pkg::TagRiff);
    put_le(0, 2);
    send_file(0);
    // bad tag byte is also the end of file
    put_tag(32'hFFFF_FFFF);
    send_file(0);
  endtask

  task automatic test_chunk_errors();
    // data chunk with no fmt chunk before it
    put_preamble();
    put_chunk(wavp_pkg::TagData, 4);
    put_random(4);
    send_file(0);
    // float, stereo and 8-bit formats
    put_preamble();
    put_fmt(16, FormatFloat, wavp_pkg::MonoChannels, 8000, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 2);
    put_random(2);
    send_file(0);
    put_preamble();
    put_fmt(16, wavp_pkg::FormatPcm, 16'd2, 8000, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 2);
    put_random(2);
    send_file(0);
    put_preamble();
    put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 8000, 16'd8);
    put_chunk(wavp_pkg::TagData, 2);
    put_random(2);
    send_file(0);
    // empty fmt chunk, then a short one missing the bit depth; eof on the data header
    put_preamble();
    put_fmt(0, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 8000, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 0);
    send_file(0);
    put_preamble();
    put_fmt(14, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 8000, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 2);
    put_random(2);
    send_file(0);
    // file ends in a chunk header, in a fmt chunk and in a skipped chunk
    put_preamble();
    put_tag(TagList);
    put_le(9, 2);
    send_file(0);
    put_preamble();
    put_chunk(wavp_pkg::TagFmt, 16);
    put_le(32'(wavp_pkg::FormatPcm), 2);
    send_file(0);
    put_preamble();
    put_chunk(TagList, 32'hFFFF_FFFF);
    put_random(6);
    send_file(0);
  endtask

  task automatic test_accepted_streams();
    // zero header rate uses the reset default, long fmt chunk, skipped chunks,
    // sample extremes, odd byte dropped, bytes past the data chunk ignored
    put_preamble();
    put_chunk(TagList, 3);
    put_random(3);
    put_chunk(32'h6A75_6E6B, 0);
    put_fmt(18, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 0, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 9);
    put_le(32'h7FFF_8000, 4);
    put_le(32'hFFFF_0000, 4);
    put_random(4);
    send_file(0);
    // last fmt chunk wins; endless data chunk cut by eof on a sample
    put_preamble();
    put_fmt(16, FormatFloat, 16'd2, 8000, 16'd8);
    put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 32'hFFFF_FFFF,
            wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 32'hFFFF_FFFF);
    put_random(6);
    send_file(0);
    // eof on the byte that completes the data header
    put_preamble();
    put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 44100, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 4);
    send_file(0);
    // one-byte data chunk, then a file cut in the middle of a sample
    put_preamble();
    put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 22050, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 1);
    put_random(2);
    send_file(0);
    put_preamble();
    put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 22050, wavp_pkg::NeededBits);
    put_chunk(wavp_pkg::TagData, 8);
    put_random(3);
    send_file(0);
  endtask

  task automatic test_default_rate();
    logic [31:0] rates[4];
    rates = '{32'd0, 32'hFFFF_FFFF, 32'($urandom), wavp_pkg::DefaultRateReset};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      put_preamble();
      put_fmt(16, wavp_pkg::FormatPcm, wavp_pkg::MonoChannels, 0, wavp_pkg::NeededBits);
      put_chunk(wavp_pkg::TagData, 2);
      put_random(2);
      send_file(0);
    end
  endtask

  task automatic test_random_files(input int unsigned target);
    int unsigned roll;
    int unsigned n;
    int unsigned cut;
    logic [31:0] len;
    logic [31:0] rate;
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] bits;
    while (bytes_sent < target) begin
      full_rate <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        roll = $urandom_range(0, 3);
        write_rate(roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF :
                   roll == 2 ? wavp_pkg::DefaultRateReset : 32'($urandom));
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        put_random($urandom_range(1, 20));
      end else if (roll < 12) begin
        put_tag(wavp_pkg::TagRiff);
        put_random($urandom_range(1, 24));
      end else begin
        put_preamble();
        if ($urandom_range(0, 19) == 0) wav_bytes[$urandom_range(0, 11)] = 8'($urandom);
        repeat ($urandom_range(0, 2)) begin
          n = $urandom_range(0, 12);
          put_chunk(($urandom_range(0, 1) != 0) ? TagList : 32'($urandom), n);
          put_random(n);
        end
        roll = $urandom_range(0, 19);
        n = (roll == 0) ? 0 : (roll < 3) ? 2 : 1;
        repeat (n) begin
          code = wavp_pkg::FormatPcm;
          chans = wavp_pkg::MonoChannels;
          bits = wavp_pkg::NeededBits;
          roll = $urandom_range(0, 3);
          rate = roll == 0 ? 32'd0 : roll == 1 ? 32'd8000 : roll == 2 ? 32'd44100 :
                 32'($urandom);
          roll = $urandom_range(0, 9);
          if (roll == 0) code = 16'($urandom_range(0, 3));
          else if (roll == 1) chans = 16'($urandom_range(0, 2));
          else if (roll == 2) bits = ($urandom_range(0, 1) != 0) ? 16'd8 : 16'($urandom);
          roll = $urandom_range(0, 19);
          len = roll < 14 ? 32'd16 : roll < 17 ? $urandom_range(17, 24) : $urandom_range(0, 15);
          put_fmt(len, code, chans, rate, bits);
        end
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(0, 6);
          put_chunk(TagList, n);
          put_random(n);
        end
        if ($urandom_range(0, 19) != 0) begin
          roll = $urandom_range(0, 19);
          len = (roll == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 255) :
                (roll == 1) ? 32'($urandom) : $urandom_range(0, 48);
          put_chunk(wavp_pkg::TagData, len);
          if (len > 48) put_random($urandom_range(0, 20));
          else put_random(len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
        end
      end
      // cut the file short at a random point
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, wav_bytes.size());
        while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
      end
      send_file(2);
    end
    full_rate <= 1'b0;
  endtask

  initial begin
    rate_setting = wavp_pkg::DefaultRateReset;
    rearm_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preamble_errors();
    test_chunk_errors();
    test_accepted_streams();
    test_default_rate();
    test_random_files(RandomBytes);
    drain(4);
    if (mismatch_count == 0 && wav_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
